// File: hdl/x86e_pkg.sv
// Shared types and encoding constants for the x86 subset instruction encoder.
`default_nettype none

package x86e_pkg;

	// Longest encoding: opcode, ModRM, SIB and a 32-bit displacement.
	localparam int unsigned MAX_BYTES = 7;

	// Mnemonic codes.
	localparam logic [3:0] CMD_NOP  = 4'd0;
	localparam logic [3:0] CMD_RET  = 4'd1;
	localparam logic [3:0] CMD_PUSH = 4'd2;
	localparam logic [3:0] CMD_POP  = 4'd3;
	localparam logic [3:0] CMD_MOV  = 4'd4;
	localparam logic [3:0] CMD_ADD  = 4'd5;
	localparam logic [3:0] CMD_SUB  = 4'd6;
	localparam logic [3:0] CMD_CMP  = 4'd7;
	localparam logic [3:0] CMD_JMP  = 4'd8;
	localparam logic [3:0] CMD_CALL = 4'd9;
	localparam logic [3:0] CMD_JE   = 4'd10;
	localparam logic [3:0] CMD_JNE  = 4'd11;
	localparam logic [3:0] CMD_INT  = 4'd12;
	localparam logic [3:0] CMD_INC  = 4'd13;
	localparam logic [3:0] CMD_DEC  = 4'd14;

	// Operand kinds.
	localparam logic [1:0] KIND_REG = 2'd0;
	localparam logic [1:0] KIND_IMM = 2'd1;
	localparam logic [1:0] KIND_MEM = 2'd2;

	localparam logic [2:0] REG_ESP = 3'd4;

	// Opcode and fixed bytes.
	localparam logic [7:0] OP_NOP      = 8'h90;
	localparam logic [7:0] OP_RET      = 8'hC3;
	localparam logic [7:0] OP_PUSH     = 8'h50;
	localparam logic [7:0] OP_POP      = 8'h58;
	localparam logic [7:0] OP_INC      = 8'h40;
	localparam logic [7:0] OP_DEC      = 8'h48;
	localparam logic [7:0] OP_MOV_IMM  = 8'hB8;
	localparam logic [7:0] OP_MOV_LOAD = 8'h8B;
	localparam logic [7:0] OP_MOV_STOR = 8'h89;
	localparam logic [7:0] OP_ADD      = 8'h01;
	localparam logic [7:0] OP_SUB      = 8'h29;
	localparam logic [7:0] OP_CMP      = 8'h39;
	localparam logic [7:0] OP_JMP      = 8'hE9;
	localparam logic [7:0] OP_CALL     = 8'hE8;
	localparam logic [7:0] OP_ESCAPE   = 8'h0F;
	localparam logic [7:0] OP_JE       = 8'h84;
	localparam logic [7:0] OP_JNE      = 8'h85;
	localparam logic [7:0] OP_INT      = 8'hCD;
	localparam logic [7:0] SIB_ESP     = 8'h24;
	localparam logic [1:0] MOD_DISP32  = 2'b10;
	localparam logic [1:0] MOD_REG     = 2'b11;

	typedef struct packed {
		logic [3:0]         cmd;
		logic [1:0]         num_operands;
		logic [1:0]         first_kind;
		logic [1:0]         second_kind;
		logic [2:0]         first_reg;
		logic [2:0]         second_reg;
		logic signed [31:0] immediate;
		logic               mem_has_base;
		logic               mem_has_index;
		logic [2:0]         mem_base_reg;
		logic signed [31:0] displacement;
	} instr_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic [2:0] byte_position;
		logic       last_byte;
		logic       unsupported;
	} code_t;

	// One fully encoded instruction as it sits in the queue.
	typedef struct packed {
		logic [0:MAX_BYTES-1][7:0] bytes;
		logic [2:0]                len;
		logic                      unsupported;
	} entry_t;

	// Queue head as seen by the back end.
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

endpackage

`default_nettype wire

// File: hdl/x86_subset_instruction_encoder.sv
// Top level of the x86 subset instruction encoder: front end, queue and byte serializer.
//
//   Channel  Direction  Handshake                 Payload
//   instr    in         instr_valid/instr_ready   x86e_pkg::instr_t, one decoded instruction
//   code     out        code_valid/code_ready     x86e_pkg::code_t, one machine code byte
//
// Each instruction item leaves as 1 to 7 code items, one per cycle while code_ready is high;
// the back end's byte serializer sets that rate, so single-byte instructions flow at one
// item per cycle. An accepted instruction is encoded and registered in the front end, then
// written to the queue, and its bytes are registered from the queue head onto code.
// Reset clears the valid flags, pointers and byte index; no clearing pass is needed.
// A stalled output register holds; the front register and queue absorb items until full.
`default_nettype none

module x86_subset_instruction_encoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire x86e_pkg::instr_t instr,
	input  wire logic             instr_valid,
	output logic                  instr_ready,
	output x86e_pkg::code_t       code,
	output logic                  code_valid,
	input  wire logic             code_ready
);

	x86e_pkg::entry_t front_entry;
	logic             front_valid;
	logic             queue_ready;
	x86e_pkg::head_t  head;
	logic             pop;

	// Classifies and encodes each instruction into a full byte image.
	x86e_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr       (instr),
		.instr_valid (instr_valid),
		.instr_ready (instr_ready),
		.entry_valid (front_valid),
		.entry       (front_entry),
		.entry_ready (queue_ready)
	);

	// Decouples encoding from the byte-by-byte output so each side stalls on its own.
	x86e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_entry (front_entry),
		.wr_ready (queue_ready),
		.head     (head),
		.pop      (pop)
	);

	// Emits the head instruction's bytes in order and retires it on its last byte.
	x86e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.code       (code),
		.code_valid (code_valid),
		.code_ready (code_ready)
	);

endmodule

`default_nettype wire

// File: hdl/x86e_front.sv
// Front end: accepts an instruction, encodes it into bytes and registers the result.
`default_nettype none

module x86e_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire x86e_pkg::instr_t instr,
	input  wire logic             instr_valid,
	output logic                  instr_ready,
	output logic                  entry_valid,
	output x86e_pkg::entry_t      entry,
	input  wire logic             entry_ready
);

	x86e_pkg::entry_t enc;
	logic             valid_s1;
	x86e_pkg::entry_t entry_s1;

	always_comb begin
		logic       one_reg;
		logic       reg_reg;
		logic       mem_ok;
		logic [2:0] mem_reg;
		logic [7:0] modrm_rr;
		logic [7:0] modrm_mem;
		logic [2:0] len;
		one_reg   = (instr.num_operands == 2'd1) && (instr.first_kind == x86e_pkg::KIND_REG);
		reg_reg   = (instr.first_kind == x86e_pkg::KIND_REG) &&
			(instr.second_kind == x86e_pkg::KIND_REG);
		mem_ok    = instr.mem_has_base && !instr.mem_has_index;
		mem_reg   = (instr.first_kind == x86e_pkg::KIND_MEM) ? instr.second_reg : instr.first_reg;
		modrm_rr  = {x86e_pkg::MOD_REG, instr.second_reg, instr.first_reg};
		modrm_mem = {x86e_pkg::MOD_DISP32, mem_reg, instr.mem_base_reg};
		enc       = '0;
		len       = 3'd0;
		unique case (instr.cmd) inside
			x86e_pkg::CMD_NOP: begin
				enc.bytes[0] = x86e_pkg::OP_NOP;
				len          = 3'd1;
			end
			x86e_pkg::CMD_RET: begin
				enc.bytes[0] = x86e_pkg::OP_RET;
				len          = 3'd1;
			end
			x86e_pkg::CMD_PUSH, x86e_pkg::CMD_POP, x86e_pkg::CMD_INC, x86e_pkg::CMD_DEC: begin
				if (one_reg) begin
					case (instr.cmd)
						x86e_pkg::CMD_PUSH: enc.bytes[0] = x86e_pkg::OP_PUSH;
						x86e_pkg::CMD_POP:  enc.bytes[0] = x86e_pkg::OP_POP;
						x86e_pkg::CMD_INC:  enc.bytes[0] = x86e_pkg::OP_INC;
						default:            enc.bytes[0] = x86e_pkg::OP_DEC;
					endcase
					enc.bytes[0][2:0] = instr.first_reg;
					len               = 3'd1;
				end
			end
			x86e_pkg::CMD_MOV: begin
				if (instr.num_operands == 2'd2 && instr.first_kind == x86e_pkg::KIND_REG &&
					instr.second_kind == x86e_pkg::KIND_IMM) begin
					enc.bytes[0] = {x86e_pkg::OP_MOV_IMM[7:3], instr.first_reg};
					enc.bytes[1] = instr.immediate[7:0];
					enc.bytes[2] = instr.immediate[15:8];
					enc.bytes[3] = instr.immediate[23:16];
					enc.bytes[4] = instr.immediate[31:24];
					len          = 3'd5;
				end else if (instr.num_operands == 2'd2 && reg_reg) begin
					enc.bytes[0] = x86e_pkg::OP_MOV_STOR;
					enc.bytes[1] = modrm_rr;
					len          = 3'd2;
				end else if (mem_ok && ((instr.first_kind == x86e_pkg::KIND_REG &&
					instr.second_kind == x86e_pkg::KIND_MEM) ||
					(instr.first_kind == x86e_pkg::KIND_MEM &&
					instr.second_kind == x86e_pkg::KIND_REG))) begin
					enc.bytes[0] = (instr.first_kind == x86e_pkg::KIND_REG) ?
						x86e_pkg::OP_MOV_LOAD : x86e_pkg::OP_MOV_STOR;
					enc.bytes[1] = modrm_mem;
					if (instr.mem_base_reg == x86e_pkg::REG_ESP) begin
						// ESP as a base can only be named through a SIB byte.
						enc.bytes[2] = x86e_pkg::SIB_ESP;
						enc.bytes[3] = instr.displacement[7:0];
						enc.bytes[4] = instr.displacement[15:8];
						enc.bytes[5] = instr.displacement[23:16];
						enc.bytes[6] = instr.displacement[31:24];
						len          = 3'd7;
					end else begin
						enc.bytes[2] = instr.displacement[7:0];
						enc.bytes[3] = instr.displacement[15:8];
						enc.bytes[4] = instr.displacement[23:16];
						enc.bytes[5] = instr.displacement[31:24];
						len          = 3'd6;
					end
				end
			end
			x86e_pkg::CMD_ADD, x86e_pkg::CMD_SUB, x86e_pkg::CMD_CMP: begin
				if (reg_reg) begin
					case (instr.cmd)
						x86e_pkg::CMD_ADD: enc.bytes[0] = x86e_pkg::OP_ADD;
						x86e_pkg::CMD_SUB: enc.bytes[0] = x86e_pkg::OP_SUB;
						default:           enc.bytes[0] = x86e_pkg::OP_CMP;
					endcase
					enc.bytes[1] = modrm_rr;
					len          = 3'd2;
				end
			end
			x86e_pkg::CMD_JMP, x86e_pkg::CMD_CALL: begin
				enc.bytes[0] = (instr.cmd == x86e_pkg::CMD_JMP) ?
					x86e_pkg::OP_JMP : x86e_pkg::OP_CALL;
				enc.bytes[1] = instr.immediate[7:0];
				enc.bytes[2] = instr.immediate[15:8];
				enc.bytes[3] = instr.immediate[23:16];
				enc.bytes[4] = instr.immediate[31:24];
				len          = 3'd5;
			end
			x86e_pkg::CMD_JE, x86e_pkg::CMD_JNE: begin
				enc.bytes[0] = x86e_pkg::OP_ESCAPE;
				enc.bytes[1] = (instr.cmd == x86e_pkg::CMD_JE) ?
					x86e_pkg::OP_JE : x86e_pkg::OP_JNE;
				enc.bytes[2] = instr.immediate[7:0];
				enc.bytes[3] = instr.immediate[15:8];
				enc.bytes[4] = instr.immediate[23:16];
				enc.bytes[5] = instr.immediate[31:24];
				len          = 3'd6;
			end
			x86e_pkg::CMD_INT: begin
				if (instr.num_operands == 2'd1 && instr.first_kind == x86e_pkg::KIND_IMM) begin
					enc.bytes[0] = x86e_pkg::OP_INT;
					enc.bytes[1] = instr.immediate[7:0];
					len          = 3'd2;
				end
			end
			default: begin
				len = 3'd0;
			end
		endcase
		// An unencodable form becomes a single flagged zero byte.
		if (len == 3'd0) begin
			enc.bytes       = '0;
			enc.len         = 3'd1;
			enc.unsupported = 1'b1;
		end else begin
			enc.len         = len;
			enc.unsupported = 1'b0;
		end
	end

	assign instr_ready = !valid_s1 || entry_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr_ready) begin
			valid_s1 <= instr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (instr_ready && instr_valid) begin
			entry_s1 <= enc;
		end
	end

	assign entry_valid = valid_s1;
	assign entry       = entry_s1;

endmodule

`default_nettype wire

// File: hdl/x86e_queue.sv
// Short queue of encoded instructions between the front and back ends.
`default_nettype none

module x86e_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	input  wire x86e_pkg::entry_t wr_entry,
	output logic                  wr_ready,
	output x86e_pkg::head_t       head,
	input  wire logic             pop
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	x86e_pkg::entry_t mem [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             push;
	logic             do_pop;

	assign wr_ready = (count_q != FullCnt);
	assign push     = wr_valid && wr_ready;
	assign do_pop   = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_entry;
		end
	end

	assign head.valid = (count_q != '0);
	assign head.entry = mem[rd_ptr_q];

endmodule

`default_nettype wire

// File: hdl/x86e_back.sv
// Back end: walks the queue head one byte per cycle, unless stalled, into the output register.
`default_nettype none

module x86e_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire x86e_pkg::head_t head,
	output logic                 pop,
	output x86e_pkg::code_t      code,
	output logic                 code_valid,
	input  wire logic            code_ready
);

	logic [2:0]      idx_q;
	logic            valid_q;
	x86e_pkg::code_t code_q;
	logic            load;
	logic            is_last;

	assign load    = head.valid && (!valid_q || code_ready);
	assign is_last = (idx_q == head.entry.len - 3'd1);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= is_last ? 3'd0 : idx_q + 3'd1;
				valid_q <= 1'b1;
			end else if (code_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q.code_byte     <= head.entry.bytes[idx_q];
			code_q.byte_position <= idx_q;
			code_q.last_byte     <= is_last;
			code_q.unsupported   <= head.entry.unsupported;
		end
	end

	assign code       = code_q;
	assign code_valid = valid_q;

endmodule

`default_nettype wire

// File: hdl/x86e_checker.sv
// Port-level checker for the x86 subset instruction encoder, with its bind.
`default_nettype none

module x86e_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire x86e_pkg::code_t code,
	input wire logic            code_valid,
	input wire logic            code_ready
);

	// A stalled output item stays and holds its payload.
	a_code_hold: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && !code_ready |=> code_valid && $stable(code))
		else $error("code item changed while stalled");

	// A flagged item is a lone zero byte.
	a_unsupported_form: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code.unsupported |->
		code.last_byte && code.byte_position == 3'd0 && code.code_byte == 8'h00)
		else $error("malformed unsupported item");

	// No instruction is longer than seven bytes.
	a_position_range: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid |-> code.byte_position != 3'd7)
		else $error("byte position out of range");

	// The seventh byte always ends an instruction.
	a_seventh_last: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code.byte_position == 3'd6 |-> code.last_byte)
		else $error("seventh byte not marked last");

	// A byte that follows an accepted non-final byte continues the same instruction.
	a_position_step: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_ready && !code.last_byte ##1 code_valid |->
		code.byte_position == $past(code.byte_position) + 3'd1)
		else $error("byte position did not advance");

endmodule

bind x86_subset_instruction_encoder x86e_checker u_x86e_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.code        (code),
	.code_valid  (code_valid),
	.code_ready  (code_ready)
);

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the x86 subset instruction encoder, with a byte-level scoreboard.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Codes that the package leaves out.
	localparam logic [1:0] KIND_NONE   = 2'd3;
	localparam logic [3:0] CMD_INVALID = 4'd15;

	// Run length and the no-progress limit. The limit is far above the longest
	// quiet stretch of a correct run: the longest sender gap, short receiver
	// stalls and the closing pause.
	localparam int RANDOM_ITEMS = 305;
	localparam int DRAIN_CYCLES = 16;
	localparam int IDLE_LIMIT   = 1000;

	// Holds the expected code bytes of every accepted instruction, oldest first.
	class code_scoreboard;
		x86e_pkg::code_t expected_q[$];
		logic [7:0]      enc_bytes[$];
		int              errors;
		int              checked;

		function void add_le32(logic [31:0] v);
			enc_bytes.push_back(v[7:0]);
			enc_bytes.push_back(v[15:8]);
			enc_bytes.push_back(v[23:16]);
			enc_bytes.push_back(v[31:24]);
		endfunction

		// ModRM with a 32-bit displacement; a base of ESP needs the SIB byte.
		function void add_mem(logic [2:0] reg_field, logic [2:0] base, logic [31:0] disp);
			enc_bytes.push_back({x86e_pkg::MOD_DISP32, reg_field, base});
			if (base == x86e_pkg::REG_ESP)
				enc_bytes.push_back(x86e_pkg::SIB_ESP);
			add_le32(disp);
		endfunction

		// Encodes one accepted instruction and queues the bytes it must produce.
		function void note_instr(x86e_pkg::instr_t i);
			logic one_reg;
			logic reg_reg;
			logic mem_ok;
			int   n;
			one_reg = (i.num_operands == 2'd1) && (i.first_kind == x86e_pkg::KIND_REG);
			reg_reg = (i.first_kind == x86e_pkg::KIND_REG) &&
				(i.second_kind == x86e_pkg::KIND_REG);
			mem_ok  = i.mem_has_base && !i.mem_has_index;
			enc_bytes.delete();
			case (i.cmd)
				x86e_pkg::CMD_NOP: enc_bytes.push_back(x86e_pkg::OP_NOP);
				x86e_pkg::CMD_RET: enc_bytes.push_back(x86e_pkg::OP_RET);
				x86e_pkg::CMD_PUSH:
					if (one_reg) enc_bytes.push_back(x86e_pkg::OP_PUSH + 8'(i.first_reg));
				x86e_pkg::CMD_POP:
					if (one_reg) enc_bytes.push_back(x86e_pkg::OP_POP + 8'(i.first_reg));
				x86e_pkg::CMD_INC:
					if (one_reg) enc_bytes.push_back(x86e_pkg::OP_INC + 8'(i.first_reg));
				x86e_pkg::CMD_DEC:
					if (one_reg) enc_bytes.push_back(x86e_pkg::OP_DEC + 8'(i.first_reg));
				x86e_pkg::CMD_MOV: begin
					if (i.num_operands == 2'd2 && i.first_kind == x86e_pkg::KIND_REG &&
							i.second_kind == x86e_pkg::KIND_IMM) begin
						enc_bytes.push_back(x86e_pkg::OP_MOV_IMM + 8'(i.first_reg));
						add_le32(i.immediate);
					end else if (i.num_operands == 2'd2 && reg_reg) begin
						enc_bytes.push_back(x86e_pkg::OP_MOV_STOR);
						enc_bytes.push_back({x86e_pkg::MOD_REG, i.second_reg, i.first_reg});
					end else if (i.first_kind == x86e_pkg::KIND_REG &&
							i.second_kind == x86e_pkg::KIND_MEM) begin
						if (mem_ok) begin
							enc_bytes.push_back(x86e_pkg::OP_MOV_LOAD);
							add_mem(i.first_reg, i.mem_base_reg, i.displacement);
						end
					end else if (i.first_kind == x86e_pkg::KIND_MEM &&
							i.second_kind == x86e_pkg::KIND_REG) begin
						if (mem_ok) begin
							enc_bytes.push_back(x86e_pkg::OP_MOV_STOR);
							add_mem(i.second_reg, i.mem_base_reg, i.displacement);
						end
					end
				end
				x86e_pkg::CMD_ADD, x86e_pkg::CMD_SUB, x86e_pkg::CMD_CMP: begin
					if (reg_reg) begin
						enc_bytes.push_back(i.cmd == x86e_pkg::CMD_ADD ? x86e_pkg::OP_ADD :
							(i.cmd == x86e_pkg::CMD_SUB ? x86e_pkg::OP_SUB : x86e_pkg::OP_CMP));
						enc_bytes.push_back({x86e_pkg::MOD_REG, i.second_reg, i.first_reg});
					end
				end
				x86e_pkg::CMD_JMP, x86e_pkg::CMD_CALL: begin
					enc_bytes.push_back(i.cmd == x86e_pkg::CMD_JMP ?
						x86e_pkg::OP_JMP : x86e_pkg::OP_CALL);
					add_le32(i.immediate);
				end
				x86e_pkg::CMD_JE, x86e_pkg::CMD_JNE: begin
					enc_bytes.push_back(x86e_pkg::OP_ESCAPE);
					enc_bytes.push_back(i.cmd == x86e_pkg::CMD_JE ?
						x86e_pkg::OP_JE : x86e_pkg::OP_JNE);
					add_le32(i.immediate);
				end
				x86e_pkg::CMD_INT: begin
					if (i.num_operands == 2'd1 && i.first_kind == x86e_pkg::KIND_IMM) begin
						enc_bytes.push_back(x86e_pkg::OP_INT);
						enc_bytes.push_back(i.immediate[7:0]);
					end
				end
				default: ;
			endcase
			n = enc_bytes.size();
			if (n == 0)
				expected_q.push_back(x86e_pkg::code_t'{code_byte: 8'h00, byte_position: 3'd0,
					last_byte: 1'b1, unsupported: 1'b1});
			else
				for (int k = 0; k < n; k++)
					expected_q.push_back(x86e_pkg::code_t'{code_byte: enc_bytes[k],
						byte_position: 3'(k), last_byte: (k == n - 1), unsupported: 1'b0});
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("ERROR at %0t, code item %0d, %s: got 0x%0h, want 0x%0h",
				$realtime, checked, what, got, want);
		endtask

		task check_code(x86e_pkg::code_t got);
			x86e_pkg::code_t want;
			if (expected_q.size() == 0) begin
				report("code item with nothing expected", 32'(got), 32'd0);
				return;
			end
			want = expected_q.pop_front();
			if (got.code_byte !== want.code_byte)
				report("code_byte", 32'(got.code_byte), 32'(want.code_byte));
			if (got.byte_position !== want.byte_position)
				report("byte_position", 32'(got.byte_position), 32'(want.byte_position));
			if (got.last_byte !== want.last_byte)
				report("last_byte", 32'(got.last_byte), 32'(want.last_byte));
			if (got.unsupported !== want.unsupported)
				report("unsupported", 32'(got.unsupported), 32'(want.unsupported));
			checked++;
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	x86e_pkg::instr_t instr;
	logic             instr_valid;
	logic             instr_ready;
	x86e_pkg::code_t  code;
	logic             code_valid;
	logic             code_ready;

	code_scoreboard sb;
	int             idle_cycles = 0;
	int             rx_cycle;

	x86_subset_instruction_encoder #(
		.QUEUE_DEPTH (2)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr       (instr),
		.instr_valid (instr_valid),
		.instr_ready (instr_ready),
		.code        (code),
		.code_valid  (code_valid),
		.code_ready  (code_ready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random instruction, mostly steered to an encodable shape.
	function automatic x86e_pkg::instr_t rand_instr();
		x86e_pkg::instr_t i;
		int               shape;
		i.cmd           = 4'($urandom_range(0, 15));
		i.num_operands  = 2'($urandom_range(0, 3));
		i.first_kind    = 2'($urandom_range(0, 3));
		i.second_kind   = 2'($urandom_range(0, 3));
		i.first_reg     = 3'($urandom_range(0, 7));
		i.second_reg    = 3'($urandom_range(0, 7));
		i.immediate     = $urandom();
		i.mem_has_base  = 1'($urandom_range(0, 1));
		i.mem_has_index = 1'($urandom_range(0, 1));
		i.mem_base_reg  = 3'($urandom_range(0, 7));
		i.displacement  = $urandom();
		shape           = $urandom_range(0, 9);
		if (shape < 7) begin
			case (i.cmd)
				x86e_pkg::CMD_NOP, x86e_pkg::CMD_RET: begin
					i.num_operands = 2'd0;
					i.first_kind   = KIND_NONE;
					i.second_kind  = KIND_NONE;
				end
				x86e_pkg::CMD_PUSH, x86e_pkg::CMD_POP, x86e_pkg::CMD_INC, x86e_pkg::CMD_DEC: begin
					i.num_operands = 2'd1;
					i.first_kind   = x86e_pkg::KIND_REG;
				end
				x86e_pkg::CMD_MOV: begin
					case (shape % 4)
						0: begin
							i.num_operands = 2'd2;
							i.first_kind   = x86e_pkg::KIND_REG;
							i.second_kind  = x86e_pkg::KIND_IMM;
						end
						1: begin
							i.num_operands = 2'd2;
							i.first_kind   = x86e_pkg::KIND_REG;
							i.second_kind  = x86e_pkg::KIND_REG;
						end
						2: begin
							i.first_kind    = x86e_pkg::KIND_REG;
							i.second_kind   = x86e_pkg::KIND_MEM;
							i.mem_has_base  = 1'b1;
							i.mem_has_index = 1'b0;
						end
						default: begin
							i.first_kind    = x86e_pkg::KIND_MEM;
							i.second_kind   = x86e_pkg::KIND_REG;
							i.mem_has_base  = 1'b1;
							i.mem_has_index = 1'b0;
						end
					endcase
					if ($urandom_range(0, 2) == 0)
						i.mem_base_reg = x86e_pkg::REG_ESP;
				end
				x86e_pkg::CMD_ADD, x86e_pkg::CMD_SUB, x86e_pkg::CMD_CMP: begin
					i.first_kind  = x86e_pkg::KIND_REG;
					i.second_kind = x86e_pkg::KIND_REG;
				end
				x86e_pkg::CMD_INT: begin
					i.num_operands = 2'd1;
					i.first_kind   = x86e_pkg::KIND_IMM;
				end
				default: ;
			endcase
		end else if (shape == 9) begin
			i.cmd = CMD_INVALID;
		end
		return i;
	endfunction

	// Presents one item and returns at the edge that accepts it, with valid still high.
	task automatic send_instr(input x86e_pkg::instr_t item);
		instr       <= item;
		instr_valid <= 1'b1;
		do @(posedge clk); while (!instr_ready);
	endtask

	task automatic idle(input int cycles);
		instr_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Holds the sender until every expected byte has come out.
	task automatic drain();
		instr_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
	endtask

	// The receiver drops ready over part of each rx_cycle period, and at random one time in five between.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_cycle   <= 0;
			code_ready <= 1'b0;
		end else begin
			rx_cycle   <= rx_cycle + 1;
			code_ready <= (rx_cycle % 23 < 17) && ($urandom_range(0, 4) != 0);
		end
	end

	// Watches both channels, feeds the scoreboard and guards against a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (instr_valid && instr_ready)
				sb.note_instr(instr);
			if (code_valid && code_ready)
				sb.check_code(code);
			if ((instr_valid && instr_ready) || (code_valid && code_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		x86e_pkg::instr_t item;
		int               burst;
		int               gap;
		int               sent;
		sb          = new();
		arst_n      <= 1'b0;
		instr       <= '0;
		instr_valid <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Longest form: a load through an ESP base.
		item               = '0;
		item.cmd           = x86e_pkg::CMD_MOV;
		item.first_kind    = x86e_pkg::KIND_REG;
		item.second_kind   = x86e_pkg::KIND_MEM;
		item.first_reg     = 3'd7;
		item.mem_has_base  = 1'b1;
		item.mem_base_reg  = x86e_pkg::REG_ESP;
		item.displacement  = 32'h80402010;
		send_instr(item);
		// The matching store.
		item.first_kind    = x86e_pkg::KIND_MEM;
		item.second_kind   = x86e_pkg::KIND_REG;
		item.second_reg    = 3'd2;
		send_instr(item);
		// A memory operand with an index cannot be encoded.
		item.mem_has_index = 1'b1;
		send_instr(item);
		// PUSH with an operand count of three fails its count check.
		item               = '0;
		item.cmd           = x86e_pkg::CMD_PUSH;
		item.num_operands  = 2'd3;
		send_instr(item);
		// The invalid mnemonic.
		item.cmd           = CMD_INVALID;
		send_instr(item);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
				send_instr(rand_instr());
				sent++;
				if (sent == RANDOM_ITEMS / 2)
					drain();
			end
			gap = $urandom_range(0, 20);
			if (gap > 0)
				idle(gap);
		end

		instr_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
hdl/x86e_pkg.sv
hdl/x86e_front.sv
hdl/x86e_queue.sv
hdl/x86e_back.sv
hdl/x86_subset_instruction_encoder.sv
hdl/x86e_checker.sv
verif/testbench.sv
